/* src/icf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icf_pkg
// shared types and constants of the image chunk framer
// ----------------------------------------------------------------------------
package icf_pkg;
  localparam int SLOT_COUNT  = 8;
  localparam int FRAME_BYTES = 250;
  localparam int HDR_BYTES   = 10;
  localparam int PAY_BYTES   = FRAME_BYTES - HDR_BYTES;
  localparam int SW          = $clog2(SLOT_COUNT);
  localparam int AW          = $clog2(SLOT_COUNT * PAY_BYTES);
  localparam logic [7:0] MARK_HEAD = 8'hAA;
  localparam logic [7:0] MARK_TAIL = 8'hBB;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_ANN   = 2'd1;
  localparam logic [1:0] CMD_RST   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LINK   = 2'd1;
  localparam logic [1:0] ST_NOSLOT = 2'd2;
  localparam logic [1:0] ST_END    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_RDMEM, S_OUT
  } state_t;

  typedef struct packed {
    logic       we;
    logic [AW-1:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

/* src/icf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icf_ram
// payload store for all slots, one write and one registered read
// ----------------------------------------------------------------------------
module icf_ram (
  input  wire logic               clk,
  input  wire icf_pkg::mem_req_t  req,
  output logic [7:0]              rdata
);
  logic [7:0] mem [icf_pkg::SLOT_COUNT * icf_pkg::PAY_BYTES];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

/* src/image_chunk_framer_slot_pool.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_chunk_framer_slot_pool
// packs image bytes into header framed slots and reads frames out by sequence
// ----------------------------------------------------------------------------
// in_* carries one command beat (data, announce, link reset, read); out_*
// returns exactly one result beat per command. cfg_* writes link_enable.
// The result beat is valid after a command has passed the scan, execute
// and payload memory read states: in the scan one compare unit walks the
// SLOT_COUNT slots one per cycle to find the free fill slot or the oldest
// ready frame. With no receiver stall the next command is taken once the
// block is back in its idle state between commands.
// Announce closes open slots during the same walk. in_stall is high from
// acceptance until the result beat is taken; a stalled out_* beat holds.
// Synchronous reset clears all slot flags and counters; payload memory is
// not cleared, bytes past a slot's length read as zero.
// ----------------------------------------------------------------------------
module image_chunk_framer_slot_pool (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_notify_last,
  input  wire logic [31:0] in_new_image_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_frame_completed,
  output logic             out_out_valid,
  output logic [7:0]       out_out_byte,
  output logic             out_out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_link_enable
);
  localparam int SC = icf_pkg::SLOT_COUNT;
  localparam int SW = icf_pkg::SW;
  localparam int AW = icf_pkg::AW;
  localparam int PB = icf_pkg::PAY_BYTES;

  icf_pkg::state_t state_r, state_nxt;
  logic [7:0]  len_r   [SC];
  logic [31:0] isz_r   [SC];
  logic [31:0] soff_r  [SC];
  logic [31:0] seq_r   [SC];
  logic [SC-1:0] rdy_r, busy_r;
  logic [SW-1:0] fill_r, rslot_r;
  logic [31:0] nseq_r, isize_r, ioff_r;
  logic        iact_r;
  logic [1:0]  drop_r;
  logic [7:0]  rpos_r;
  logic        link_r;

  logic [1:0]  cmd_r;
  logic [7:0]  db_r;
  logic        nl_r;
  logic [31:0] nsz_r;

  logic [SW:0]   cnt_r;
  logic          ffound_r, bfound_r, any_r;
  logic [SW-1:0] ffirst_r, best_r;
  logic [31:0]   bseq_r;

  logic [1:0] ost_r;
  logic       odone_r, ov_r, olast_r, omem_r;
  logic [7:0] obyte_r;
  logic       out_valid_r;
  logic [7:0] rdata;
  icf_pkg::mem_req_t req;

  icf_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  logic [SW-1:0] ci;
  assign ci = cnt_r[SW-1:0];
  assign in_stall  = (state_r != icf_pkg::S_IDLE);
  assign cfg_ready = (state_r == icf_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = ost_r;
  assign out_frame_completed = odone_r;
  assign out_out_valid = ov_r;
  assign out_out_byte = omem_r ? rdata : obyte_r;
  assign out_out_last = olast_r;

  function automatic logic [31:0] ostep(logic [31:0] off, logic [31:0] sz, logic act);
    logic [31:0] r;
    r = off + 32'd1;
    if (act && sz != 32'd0 && off >= sz) r = off;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= icf_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      icf_pkg::S_IDLE:  if (in_valid) state_nxt = icf_pkg::S_SCAN;
      icf_pkg::S_SCAN:  if (cnt_r == (SW+1)'(SC - 1)) state_nxt = icf_pkg::S_EXEC;
      icf_pkg::S_EXEC:  state_nxt = icf_pkg::S_RDMEM;
      icf_pkg::S_RDMEM: state_nxt = icf_pkg::S_OUT;
      icf_pkg::S_OUT:   if (!out_stall) state_nxt = icf_pkg::S_IDLE;
      default:          state_nxt = icf_pkg::S_IDLE;
    endcase
  end

  // execute cycle decisions
  logic [SW-1:0] fs, rs;
  logic          ffree, rok;
  logic [7:0]    p;
  logic [AW-1:0] rd_addr;
  logic          rd_mem;
  always_comb begin
    ffree = !rdy_r[fill_r] && !busy_r[fill_r];
    fs = ffree ? fill_r : ffirst_r;
    rok = busy_r[rslot_r] || bfound_r;
    rs = busy_r[rslot_r] ? rslot_r : best_r;
    p  = busy_r[rslot_r] ? rpos_r : 8'd0;
    rd_mem = (p >= 8'(icf_pkg::HDR_BYTES)) &&
             ((p - 8'(icf_pkg::HDR_BYTES)) < len_r[rs]);
    rd_addr = AW'(rs) * AW'(PB) + AW'(p - 8'(icf_pkg::HDR_BYTES));
    req = '0;
    if (state_r == icf_pkg::S_EXEC && cmd_r == icf_pkg::CMD_READ && link_r && rok) begin
      req.re = rd_mem;
      req.raddr = rd_addr;
    end
    if (state_r == icf_pkg::S_EXEC && cmd_r == icf_pkg::CMD_DATA && link_r &&
        drop_r == icf_pkg::ST_OK && !(iact_r && ioff_r >= isize_r) &&
        (ffree || ffound_r) && len_r[fs] < 8'(PB)) begin
      req.we = 1'b1;
      req.waddr = AW'(fs) * AW'(PB) + AW'(len_r[fs]);
      req.wdata = db_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] noff;
    logic        done, nact;
    logic [SW-1:0] nf;
    logic [7:0]  nlen;
    if (!rst_n) begin
      for (int i = 0; i < SC; i++) begin
        len_r[i] <= '0; isz_r[i] <= '0; soff_r[i] <= '0; seq_r[i] <= '0;
      end
      rdy_r <= '0; busy_r <= '0; fill_r <= '0; rslot_r <= '0;
      nseq_r <= '0; isize_r <= '0; ioff_r <= '0; iact_r <= 1'b0;
      drop_r <= '0; rpos_r <= '0; link_r <= 1'b0; out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) link_r <= cfg_link_enable;
      case (state_r)
        icf_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command; db_r <= in_data_byte;
            nl_r <= in_notify_last; nsz_r <= in_new_image_size;
            cnt_r <= '0; ffound_r <= 1'b0; bfound_r <= 1'b0; any_r <= 1'b0;
            ffirst_r <= '0; best_r <= '0; bseq_r <= '0;
          end
        end
        icf_pkg::S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          // link reset wants the first slot not being read, ready or not
          if (!ffound_r && !busy_r[ci] && (cmd_r == icf_pkg::CMD_RST || !rdy_r[ci])) begin
            ffound_r <= 1'b1; ffirst_r <= ci;
          end
          if (rdy_r[ci] && !busy_r[ci] && (!bfound_r || seq_r[ci] < bseq_r)) begin
            bfound_r <= 1'b1; best_r <= ci; bseq_r <= seq_r[ci];
          end
          if (cmd_r == icf_pkg::CMD_ANN && len_r[ci] != 8'd0 && !rdy_r[ci] && !busy_r[ci]) begin
            seq_r[ci] <= nseq_r; nseq_r <= nseq_r + 32'd1; rdy_r[ci] <= 1'b1;
            any_r <= 1'b1;
            if (fill_r == ci) fill_r <= SW'((32'(ci) + 1) % SC);
          end
        end
        icf_pkg::S_EXEC: begin
          ost_r <= icf_pkg::ST_OK; odone_r <= 1'b0; ov_r <= 1'b0;
          obyte_r <= '0; olast_r <= 1'b0; omem_r <= 1'b0;
          case (cmd_r)
            icf_pkg::CMD_DATA: begin
              if (!link_r) begin
                ost_r <= icf_pkg::ST_LINK;
                if (nl_r) drop_r <= icf_pkg::ST_OK;
              end else if (drop_r != icf_pkg::ST_OK) begin
                ost_r <= drop_r;
                if (drop_r == icf_pkg::ST_NOSLOT) begin
                  noff = ostep(ioff_r, isize_r, iact_r);
                  ioff_r <= noff;
                  if (iact_r && noff >= isize_r) iact_r <= 1'b0;
                end
                if (nl_r) drop_r <= icf_pkg::ST_OK;
              end else if (iact_r && ioff_r >= isize_r) begin
                ost_r <= icf_pkg::ST_END;
                if (!nl_r) drop_r <= icf_pkg::ST_END;
              end else if (!ffree && !ffound_r) begin
                ost_r <= icf_pkg::ST_NOSLOT;
                noff = ostep(ioff_r, isize_r, iact_r);
                ioff_r <= noff;
                if (iact_r && noff >= isize_r) iact_r <= 1'b0;
                if (!nl_r) drop_r <= icf_pkg::ST_NOSLOT;
              end else begin
                if (len_r[fs] == 8'd0) begin
                  isz_r[fs] <= isize_r; soff_r[fs] <= ioff_r;
                end
                nlen = (len_r[fs] < 8'(PB)) ? len_r[fs] + 8'd1 : len_r[fs];
                len_r[fs] <= nlen;
                noff = ostep(ioff_r, isize_r, iact_r);
                nact = iact_r && !(noff >= isize_r);
                ioff_r <= noff; iact_r <= nact;
                done = iact_r && isize_r != 32'd0 && noff >= isize_r;
                fill_r <= fs;
                if (nlen >= 8'(PB) || done) begin
                  seq_r[fs] <= nseq_r; nseq_r <= nseq_r + 32'd1;
                  rdy_r[fs] <= 1'b1;
                  nf = SW'((32'(fs) + 1) % SC);
                  fill_r <= nf;
                  if (nf != fs && !rdy_r[nf] && !busy_r[nf]) begin
                    len_r[nf] <= '0; isz_r[nf] <= '0; soff_r[nf] <= '0; seq_r[nf] <= '0;
                  end
                  odone_r <= 1'b1;
                end
                if (done && !nl_r) drop_r <= icf_pkg::ST_END;
              end
            end
            icf_pkg::CMD_ANN: begin
              odone_r <= any_r;
              isize_r <= nsz_r; ioff_r <= '0; iact_r <= (nsz_r != 32'd0);
              drop_r <= icf_pkg::ST_OK;
            end
            icf_pkg::CMD_RST: begin
              rdy_r <= '0;
              for (int i = 0; i < SC; i++) begin
                if (!busy_r[i]) begin
                  len_r[i] <= '0; isz_r[i] <= '0; soff_r[i] <= '0; seq_r[i] <= '0;
                end
              end
              fill_r <= ffound_r ? ffirst_r : '0;
              isize_r <= '0; ioff_r <= '0; iact_r <= 1'b0; drop_r <= icf_pkg::ST_OK;
            end
            default: begin
              if (!link_r) ost_r <= icf_pkg::ST_LINK;
              else if (rok) begin
                ov_r <= 1'b1;
                rslot_r <= rs;
                busy_r[rs] <= 1'b1;
                omem_r <= rd_mem;
                if (p == 8'd0) obyte_r <= icf_pkg::MARK_HEAD;
                else if (p <= 8'd4) obyte_r <= 8'(isz_r[rs] >> (8 * (p - 8'd1)));
                else if (p <= 8'd8) obyte_r <= 8'(soff_r[rs] >> (8 * (p - 8'd5)));
                else if (p == 8'd9) obyte_r <= icf_pkg::MARK_TAIL;
                if (32'(p) + 1 >= icf_pkg::FRAME_BYTES) begin
                  olast_r <= 1'b1;
                  rdy_r[rs] <= 1'b0; busy_r[rs] <= 1'b0;
                  len_r[rs] <= '0; isz_r[rs] <= '0; soff_r[rs] <= '0; seq_r[rs] <= '0;
                  rpos_r <= '0;
                end else begin
                  rpos_r <= p + 8'd1;
                end
              end
            end
          endcase
        end
        icf_pkg::S_RDMEM: out_valid_r <= 1'b1;
        icf_pkg::S_OUT: if (!out_stall) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
